FILE: sv/ldfd_pkg.sv
// Shared types and constants for the LED duty frame deframer.
// No dependencies; imported by every module of the block.
`default_nettype none

package ldfd_pkg;

  // Frame format codes held in the configuration register
  localparam logic [1:0] FMT_HDR    = 2'd0;
  localparam logic [1:0] FMT_PACKED = 2'd1;
  localparam logic [1:0] FMT_ROW    = 2'd2;

  // Header bytes
  localparam logic [7:0] HDR_SYNC_A = 8'h01;
  localparam logic [7:0] HDR_SYNC_B = 8'h40;
  localparam logic [7:0] ROW_SYNC   = 8'h96;

  // Last byte positions of the fixed-length formats
  localparam logic [8:0] PACKED_LAST_POS = 9'd119;
  localparam logic [8:0] ROW_LAST_POS    = 9'd252;

  // Last byte index in one row pair of the row format, and duties per row
  localparam logic [5:0] ROW_PAIR_LAST = 6'd38;
  localparam logic [7:0] ROW_CHANNELS  = 8'd6;

  // Result kinds and status codes
  localparam logic KIND_DUTY   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;
  localparam logic STAT_OK     = 1'b0;
  localparam logic STAT_FAIL   = 1'b1;

  // Default depth of the request queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // All results caused by one byte. Two duties always go to ch0 and ch0+1.
  typedef struct packed {
    logic [1:0]  n_duty;
    logic [7:0]  ch0;
    logic [11:0] duty0;
    logic [11:0] duty1;
    logic        stat_vld;
    logic        stat_fail;
  } ldfd_req_t;

  // Divide a small value (at most 17) by three
  function automatic logic [2:0] div3_small(input logic [4:0] x);
    logic [8:0] prod;
    prod = 9'(x) * 9'd11;
    return prod[7:5];
  endfunction

endpackage

`default_nettype wire

FILE: sv/ldfd_front.sv
// Front end: frame position tracking and byte classification.
// Depends on ldfd_pkg; emits one request per byte that causes results.
`default_nettype none

module ldfd_front
  import ldfd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic [7:0] in_rx_byte,
  input  wire logic       in_frame_start,
  input  wire logic       fmt_wr,
  input  wire logic [1:0] fmt_data,
  input  wire logic       q_full,
  output logic            push,
  output ldfd_req_t       req
);

  logic [1:0]  fmt_r;
  logic        done_r, done_nxt;
  logic [8:0]  pos_r, pos_nxt;
  logic [1:0]  mod3_r, mod3_nxt;
  logic [6:0]  div3_r, div3_nxt;
  logic [5:0]  mod39_r, mod39_nxt;
  logic [2:0]  div39_r, div39_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [15:0] held_r, held_nxt;

  logic        go;

  always_comb begin
    logic [8:0]  p;
    logic [1:0]  m3;
    logic [6:0]  d3;
    logic [5:0]  m39;
    logic [2:0]  d39;
    logic [7:0]  s;
    logic [7:0]  dl;
    logic [15:0] h;
    logic [15:0] h_new;
    logic [7:0]  dl_new;
    logic [8:0]  lim;
    logic        active;
    logic [1:0]  ph_even;
    logic [2:0]  col;
    logic [7:0]  b;
    ldfd_req_t   r;

    b = in_rx_byte;
    // A frame start restarts every position counter and clears the frame state
    if (in_frame_start) begin
      p = '0; m3 = '0; d3 = '0; m39 = '0; d39 = '0;
      s = '0; dl = '0; h = '0;
    end else begin
      p = pos_r; m3 = mod3_r; d3 = div3_r; m39 = mod39_r; d39 = div39_r;
      s = sum_r; dl = len_r; h = held_r;
    end
    active  = in_frame_start || !done_r;
    h_new   = h;
    dl_new  = dl;
    lim     = {1'b0, dl} + 9'd3;
    ph_even = (m3 == 2'd2) ? 2'd0 : m3 + 2'd1;
    col     = '0;
    r       = '0;

    unique case (fmt_r)
      FMT_HDR: begin
        if (p == 9'd0) begin
          if (b != HDR_SYNC_A) begin
            r.stat_vld = 1'b1; r.stat_fail = STAT_FAIL;
          end
        end else if (p == 9'd1) begin
          if (b != HDR_SYNC_B) begin
            r.stat_vld = 1'b1; r.stat_fail = STAT_FAIL;
          end
        end else if (p == 9'd2) begin
          if (b == 8'd0) begin
            r.stat_vld = 1'b1; r.stat_fail = STAT_FAIL;
          end else begin
            dl_new = b;
          end
        end else if (dl == 8'd0 || p > lim) begin
          r.stat_vld = 1'b1; r.stat_fail = STAT_FAIL;
        end else if (p < lim) begin
          r.n_duty = 2'd1;
          r.ch0    = 8'(p - 9'd3);
          r.duty0  = {b, 4'h0};
        end else begin
          r.stat_vld  = 1'b1;
          r.stat_fail = (b != s) ? STAT_FAIL : STAT_OK;
        end
      end
      FMT_PACKED: begin
        if (p > PACKED_LAST_POS) begin
          r.stat_vld = 1'b1; r.stat_fail = STAT_FAIL;
        end else begin
          if (m3 == 2'd0) begin
            h_new = {b, 8'h00};
          end else if (m3 == 2'd1) begin
            h_new = {h[15:8], b};
          end else begin
            r.n_duty = 2'd2;
            r.ch0    = {d3, 1'b0};
            r.duty0  = h[15:4];
            r.duty1  = {h[3:0], b};
          end
          if (p == PACKED_LAST_POS) begin
            r.stat_vld = 1'b1; r.stat_fail = STAT_OK;
          end
        end
      end
      FMT_ROW: begin
        if (p == 9'd0) begin
          if (b != ROW_SYNC) begin
            r.stat_vld = 1'b1; r.stat_fail = STAT_FAIL;
          end
        end else if (p > ROW_LAST_POS) begin
          r.stat_vld = 1'b1; r.stat_fail = STAT_FAIL;
        end else begin
          if (m39 >= 6'd2 && m39 <= 6'd19) begin
            // Even row: low byte, then the high nibble of the next byte on top
            col = div3_small(5'(m39 - 6'd2));
            if (ph_even == 2'd0) begin
              h_new = {8'h00, b};
            end else if (ph_even == 2'd1) begin
              r.n_duty = 2'd1;
              r.ch0    = 8'(d39) * (ROW_CHANNELS << 1) + 8'(col);
              r.duty0  = {b[7:4], h[7:0]};
            end
          end else if (m39 >= 6'd21) begin
            // Odd row: byte times 16 plus the high nibble of the next byte
            col = div3_small(5'(m39 - 6'd21));
            if (m3 == 2'd0) begin
              h_new = {8'h00, b};
            end else if (m3 == 2'd1) begin
              r.n_duty = 2'd1;
              r.ch0    = 8'(d39) * (ROW_CHANNELS << 1) + ROW_CHANNELS + 8'(col);
              r.duty0  = {h[7:0], b[7:4]};
            end
          end
          if (p == ROW_LAST_POS) begin
            r.stat_vld = 1'b1; r.stat_fail = STAT_OK;
          end
        end
      end
      default: begin
        r.stat_vld = 1'b1; r.stat_fail = STAT_FAIL;
      end
    endcase

    go   = in_valid && !q_full && active;
    push = go && (r.n_duty != 2'd0 || r.stat_vld);
    req  = r;

    done_nxt  = done_r;
    pos_nxt   = pos_r;
    mod3_nxt  = mod3_r;
    div3_nxt  = div3_r;
    mod39_nxt = mod39_r;
    div39_nxt = div39_r;
    sum_nxt   = sum_r;
    len_nxt   = len_r;
    held_nxt  = held_r;
    if (go) begin
      sum_nxt  = s + b;
      len_nxt  = dl_new;
      held_nxt = h_new;
      done_nxt = r.stat_vld;
      // Advance position only while the frame stays open
      if (r.stat_vld) begin
        pos_nxt = p; mod3_nxt = m3; div3_nxt = d3; mod39_nxt = m39; div39_nxt = d39;
      end else begin
        pos_nxt   = p + 9'd1;
        mod3_nxt  = (m3 == 2'd2) ? 2'd0 : m3 + 2'd1;
        div3_nxt  = (m3 == 2'd2) ? d3 + 7'd1 : d3;
        mod39_nxt = (m39 == ROW_PAIR_LAST) ? 6'd0 : m39 + 6'd1;
        div39_nxt = (m39 == ROW_PAIR_LAST) ? d39 + 3'd1 : d39;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r   <= FMT_HDR;
      done_r  <= 1'b1;
      pos_r   <= '0;
      mod3_r  <= '0;
      div3_r  <= '0;
      mod39_r <= '0;
      div39_r <= '0;
      sum_r   <= '0;
      len_r   <= '0;
      held_r  <= '0;
    end else begin
      if (fmt_wr) begin
        fmt_r <= fmt_data;
      end
      done_r  <= done_nxt;
      pos_r   <= pos_nxt;
      mod3_r  <= mod3_nxt;
      div3_r  <= div3_nxt;
      mod39_r <= mod39_nxt;
      div39_r <= div39_nxt;
      sum_r   <= sum_nxt;
      len_r   <= len_nxt;
      held_r  <= held_nxt;
    end
  end

  // A status request closes the frame
  assert property (@(posedge clk) disable iff (!rst_n)
    push && req.stat_vld |=> done_r)
    else $error("frame left open after status request");

  // Phase counters stay in range
  assert property (@(posedge clk) disable iff (!rst_n)
    mod3_r != 2'd3 && mod39_r <= ROW_PAIR_LAST)
    else $error("position phase counter out of range");

endmodule

`default_nettype wire

FILE: sv/ldfd_fifo.sv
// Short request queue between front and back, held in flip-flops.
// Depends on ldfd_pkg for the request type.
`default_nettype none

module ldfd_fifo
  import ldfd_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  ldfd_req_t wr_req,
  input  wire logic pop,
  output ldfd_req_t head,
  output logic      empty,
  output logic      full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  ldfd_req_t        mem_r [DEPTH];
  logic [PW-1:0]    wp_r, wp_nxt;
  logic [PW-1:0]    rp_r, rp_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;

  assign empty = (cnt_r == CW'(0));
  assign full  = (cnt_r == CW'(DEPTH));
  assign head  = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + PW'(1);
    end
    if (pop) begin
      rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + PW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wr_req;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full) && !(pop && empty))
    else $error("queue overflow or underflow");

endmodule

`default_nettype wire

FILE: sv/ldfd_back.sv
// Back end: expands queued requests into result items, one per cycle
// while out_stall is low. Depends on ldfd_pkg; registers the results.
`default_nettype none

module ldfd_back
  import ldfd_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  ldfd_req_t  head,
  input  wire logic  q_empty,
  output logic       pop,
  output logic       out_valid,
  input  wire logic  out_stall,
  output logic       out_kind,
  output logic [7:0] out_channel,
  output logic [11:0] out_duty,
  output logic       out_status,
  output logic       out_last
);

  logic        valid_r, valid_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic        kind_r, kind_nxt;
  logic [7:0]  chan_r, chan_nxt;
  logic [11:0] duty_r, duty_nxt;
  logic        stat_r, stat_nxt;
  logic        last_r, last_nxt;

  always_comb begin
    logic       load;
    logic [1:0] total;
    logic       is_last;

    load    = !valid_r || !out_stall;
    total   = head.n_duty + {1'b0, head.stat_vld};
    is_last = (idx_r == total - 2'd1);

    valid_nxt = valid_r;
    idx_nxt   = idx_r;
    kind_nxt  = kind_r;
    chan_nxt  = chan_r;
    duty_nxt  = duty_r;
    stat_nxt  = stat_r;
    last_nxt  = last_r;
    pop       = 1'b0;

    if (load) begin
      valid_nxt = !q_empty;
      if (!q_empty) begin
        if (idx_r < head.n_duty) begin
          kind_nxt = KIND_DUTY;
          chan_nxt = head.ch0 + 8'(idx_r);
          duty_nxt = (idx_r == 2'd0) ? head.duty0 : head.duty1;
          stat_nxt = STAT_OK;
        end else begin
          kind_nxt = KIND_STATUS;
          chan_nxt = '0;
          duty_nxt = '0;
          stat_nxt = head.stat_fail;
        end
        last_nxt = is_last;
        // Retire the request with its last item
        pop     = is_last;
        idx_nxt = is_last ? 2'd0 : idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    chan_r <= chan_nxt;
    duty_r <= duty_nxt;
    stat_r <= stat_nxt;
    last_r <= last_nxt;
  end

  assign out_valid   = valid_r;
  assign out_kind    = kind_r;
  assign out_channel = chan_r;
  assign out_duty    = duty_r;
  assign out_status  = stat_r;
  assign out_last    = last_r;

  // A status result always closes the results of its byte
  assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && kind_r == KIND_STATUS |-> last_r && chan_r == 8'd0 && duty_r == 12'd0)
    else $error("status result not last or carries duty fields");

  // Duty results never carry a fail status
  assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && kind_r == KIND_DUTY |-> stat_r == STAT_OK)
    else $error("duty result carries a status");

endmodule

`default_nettype wire

FILE: sv/led_duty_frame_deframer.sv
// LED duty frame deframer: turns received SPI bytes into 12-bit LED duties.
// Input channel: in_valid / in_stall with in_rx_byte and in_frame_start.
//   A byte is taken on a clock edge with in_valid high and in_stall low.
//   in_frame_start on a byte restarts the frame at position zero.
// Result channel: out_valid / out_stall with out_kind, out_channel,
//   out_duty, out_status and out_last. A byte causes zero to three results;
//   out_last marks the final one. Duties are provisional until the status
//   result of the frame reports success.
// Config: cfg_valid / cfg_ready writes cfg_format_select (0 header with
//   checksum, 1 packed 80 channels, 2 rows of 78 channels, 3 always fails).
//   cfg_ready is always high; write only while the block is idle.
// Throughput: one byte per cycle while in_stall is low. Results leave one
//   per cycle while out_stall is low, so a byte with three results holds
//   the back end until all have left; the queue between front and back
//   absorbs the difference. A queued request feeds the output register.
// Stall: out_stall holds the output register; the queue fills and then
//   in_stall rises. in_stall depends on the queue level only.
// Reset (synchronous, rst_n low): format 0, queue empty, block idle until
//   the next byte with in_frame_start.
`default_nettype none

module led_duty_frame_deframer
  import ldfd_pkg::*;
#(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_rx_byte,
  input  wire logic        in_frame_start,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_kind,
  output logic [7:0]       out_channel,
  output logic [11:0]      out_duty,
  output logic             out_status,
  output logic             out_last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_format_select
);

  ldfd_req_t req;
  ldfd_req_t head;
  logic      push;
  logic      pop;
  logic      q_empty;
  logic      q_full;

  // Config writes are always taken
  assign cfg_ready = 1'b1;
  // Hold input bytes while the request queue is full
  assign in_stall  = q_full;

  ldfd_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_rx_byte     (in_rx_byte),
    .in_frame_start (in_frame_start),
    .fmt_wr         (cfg_valid && cfg_ready),
    .fmt_data       (cfg_format_select),
    .q_full         (q_full),
    .push           (push),
    .req            (req)
  );

  ldfd_fifo #(
    .DEPTH (QDEPTH)
  ) u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_req (req),
    .pop    (pop),
    .head   (head),
    .empty  (q_empty),
    .full   (q_full)
  );

  ldfd_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head        (head),
    .q_empty     (q_empty),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_kind    (out_kind),
    .out_channel (out_channel),
    .out_duty    (out_duty),
    .out_status  (out_status),
    .out_last    (out_last)
  );

endmodule

`default_nettype wire
